### design/tcl_pkg.sv
// shared types, widths and constants for the tube carriage limit clamp
// no dependencies; imported by every module of the block
package tcl_pkg;

    // field widths
    localparam int POS_W      = 22;
    localparam int WIDE_W     = 26;
    localparam int LEN_W      = 20;
    localparam int THK_W      = 16;
    localparam int TUBE_COUNT = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int TDATA_W    = 72;
    localparam int PAD_W      = TDATA_W - TUBE_COUNT * POS_W;

    typedef logic signed [POS_W-1:0]  t_pos;
    typedef logic signed [WIDE_W-1:0] t_wide;

    // positions of the three tubes, tube 1 in the low bits
    typedef struct packed {
        t_pos three;
        t_pos two;
        t_pos one;
    } t_pos_set;

    // carriage plate geometry shared by all tubes
    typedef struct packed {
        logic [THK_W-1:0] front;
        logic [THK_W-1:0] back;
        logic [THK_W-1:0] offset;
    } t_plate;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TUBE_ONE_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TUBE_TWO_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TUBE_THREE_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLATE_FRONT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLATE_BACK     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_OFFSET   = 3'd5;

    // register reset values
    localparam logic [LEN_W-1:0] LEN_RESET    = '0;
    localparam logic [THK_W-1:0] FRONT_RESET  = 16'd10000;
    localparam logic [THK_W-1:0] BACK_RESET   = 16'd10000;
    localparam logic [THK_W-1:0] OFFSET_RESET = 16'd25000;

    // tip margin behind the next outer tip, per tube
    localparam t_wide MARGIN_ONE   = 26'sd1000;
    localparam t_wide MARGIN_TWO   = 26'sd10000;
    localparam t_wide MARGIN_THREE = 26'sd1000;

    // tip reach ahead of the front plate: 1000 per tube still to come, self included
    localparam t_wide REACH_ONE   = 26'sd3000;
    localparam t_wide REACH_TWO   = 26'sd2000;
    localparam t_wide REACH_THREE = 26'sd1000;

    // upper bound of any corrected position
    localparam t_pos SAFE_MAX = 22'sd3000;

endpackage

### design/tcl_clamp.sv
// four-clamp correction of one tube position against the tube before it
// depends on tcl_pkg
module tcl_clamp
    import tcl_pkg::*;
(
    input  t_pos             i_want,
    input  t_wide            i_prev,
    input  t_wide            i_prev_len,
    input  t_wide            i_prev_front,
    input  logic [LEN_W-1:0] i_len,
    input  t_plate           i_plate,
    input  t_wide            i_ahead,
    input  t_wide            i_margin,
    input  t_wide            i_reach,
    output t_pos             o_safe
);

    t_wide len_w;
    t_wide front_w;
    t_wide back_w;
    t_wide offset_w;
    t_wide rear;
    t_wide lim;
    t_wide tip;
    t_wide flr;
    t_wide b0;
    t_wide b1;
    t_wide b2;
    t_wide b3;
    t_wide b4;

    always_comb begin
        len_w    = t_wide'(i_len);
        front_w  = t_wide'(i_plate.front);
        back_w   = t_wide'(i_plate.back);
        offset_w = t_wide'(i_plate.offset);

        b0 = t_wide'(i_want);

        // clear of the carriage behind
        rear = i_prev + i_prev_front + back_w;
        b1   = (b0 < rear) ? rear : b0;

        // room for the carriages ahead and the front plate offset
        lim = -offset_w - i_ahead - front_w;
        b2  = (b1 > lim) ? lim : b1;

        // tip stays behind the next outer tip
        tip = i_prev + i_prev_len - len_w - i_margin;
        b3  = (b2 > tip) ? tip : b2;

        // tip stays ahead of the front plate
        flr = i_reach - len_w;
        b4  = (b3 < flr) ? flr : b3;
    end

    assign o_safe = b4[POS_W-1:0];

endmodule

### design/tube_carriage_limit_clamp.sv
// top level of the tube carriage limit clamp: config registers and pipeline
// depends on tcl_pkg and tcl_clamp
//
// Corrects three requested tube carriage positions (signed micrometres) against
// the translation limits of a three-tube carriage stack. Tube 1 is checked against
// a virtual tube 0 at -2 * tube_one_length with length 3 * tube_one_length and no
// plate; tube 2 against corrected tube 1, tube 3 against corrected tube 2. Each
// tube passes four clamps in order: clear of the carriage behind, room for the
// carriages ahead plus the front plate offset, tip behind the next outer tip, and
// tip ahead of the front plate. The block takes one item per clock while the output
// is not stalled; each item passes an input register followed by three pipeline
// stages, one per tube, the last being the output register. Stages with no item
// in them fill while the output waits, so up to four items can be held during a
// stall. Configuration is a plain write port (index 0..5 in the order of the
// register list, writes to other indexes are dropped) and must only be written
// while no item is in flight.
module tube_carriage_limit_clamp
    import tcl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_W-1:0]    s_axis_tdata,   // want_pos_one, want_pos_two, want_pos_three, pad
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata    // safe_pos_one, safe_pos_two, safe_pos_three, pad
);

    // configuration registers
    logic [LEN_W-1:0] r_len_one;
    logic [LEN_W-1:0] r_len_two;
    logic [LEN_W-1:0] r_len_three;
    t_plate           r_plate;

    // pipeline: stage 0 input register, stage k holds tubes 1..k corrected
    logic [3:0] r_vld;
    t_pos_set   r_set [4];
    t_pos_set   n_set [4];
    logic [3:0] go;

    // derived geometry
    t_wide len_one_w;
    t_wide len_two_w;
    t_wide pair_w;
    t_wide zero_prev_pos;
    t_wide zero_prev_len;
    t_pos  safe_one;
    t_pos  safe_two;
    t_pos  safe_three;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_one   <= LEN_RESET;
            r_len_two   <= LEN_RESET;
            r_len_three <= LEN_RESET;
            r_plate     <= '{front: FRONT_RESET, back: BACK_RESET, offset: OFFSET_RESET};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TUBE_ONE_LEN:   r_len_one      <= i_cfg_data;
                CFG_TUBE_TWO_LEN:   r_len_two      <= i_cfg_data;
                CFG_TUBE_THREE_LEN: r_len_three    <= i_cfg_data;
                CFG_PLATE_FRONT:    r_plate.front  <= i_cfg_data[THK_W-1:0];
                CFG_PLATE_BACK:     r_plate.back   <= i_cfg_data[THK_W-1:0];
                CFG_FRONT_OFFSET:   r_plate.offset <= i_cfg_data[THK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        len_one_w     = t_wide'(r_len_one);
        len_two_w     = t_wide'(r_len_two);
        pair_w        = t_wide'(r_plate.front) + t_wide'(r_plate.back);
        // virtual tube 0
        zero_prev_pos = -(len_one_w <<< 1);
        zero_prev_len = (len_one_w <<< 1) + len_one_w;
    end

    // a stage takes a new item when empty or when its item moves on
    always_comb begin
        go[3] = !r_vld[3] || m_axis_tready;
        go[2] = !r_vld[2] || go[3];
        go[1] = !r_vld[1] || go[2];
        go[0] = !r_vld[0] || go[1];
    end

    assign s_axis_tready = go[0];

    // tube 1 against virtual tube 0
    tcl_clamp u_clamp_one (
        .i_want       (r_set[0].one),
        .i_prev       (zero_prev_pos),
        .i_prev_len   (zero_prev_len),
        .i_prev_front ('0),
        .i_len        (r_len_one),
        .i_plate      (r_plate),
        .i_ahead      (pair_w <<< 1),
        .i_margin     (MARGIN_ONE),
        .i_reach      (REACH_ONE),
        .o_safe       (safe_one)
    );

    // tube 2 against corrected tube 1
    tcl_clamp u_clamp_two (
        .i_want       (r_set[1].two),
        .i_prev       (t_wide'(r_set[1].one)),
        .i_prev_len   (len_one_w),
        .i_prev_front (t_wide'(r_plate.front)),
        .i_len        (r_len_two),
        .i_plate      (r_plate),
        .i_ahead      (pair_w),
        .i_margin     (MARGIN_TWO),
        .i_reach      (REACH_TWO),
        .o_safe       (safe_two)
    );

    // tube 3 against corrected tube 2
    tcl_clamp u_clamp_three (
        .i_want       (r_set[2].three),
        .i_prev       (t_wide'(r_set[2].two)),
        .i_prev_len   (len_two_w),
        .i_prev_front (t_wide'(r_plate.front)),
        .i_len        (r_len_three),
        .i_plate      (r_plate),
        .i_ahead      ('0),
        .i_margin     (MARGIN_THREE),
        .i_reach      (REACH_THREE),
        .o_safe       (safe_three)
    );

    always_comb begin
        n_set[0]       = s_axis_tdata[TUBE_COUNT*POS_W-1:0];
        n_set[1]       = r_set[0];
        n_set[1].one   = safe_one;
        n_set[2]       = r_set[1];
        n_set[2].two   = safe_two;
        n_set[3]       = r_set[2];
        n_set[3].three = safe_three;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (go[0]) r_vld[0] <= s_axis_tvalid;
            if (go[1]) r_vld[1] <= r_vld[0];
            if (go[2]) r_vld[2] <= r_vld[1];
            if (go[3]) r_vld[3] <= r_vld[2];
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (go[0] && s_axis_tvalid) r_set[0] <= n_set[0];
        if (go[1] && r_vld[0])      r_set[1] <= n_set[1];
        if (go[2] && r_vld[1])      r_set[2] <= n_set[2];
        if (go[3] && r_vld[2])      r_set[3] <= n_set[3];
    end

    assign m_axis_tvalid = r_vld[3];
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_set[3]};

endmodule

### design/tcl_checker.sv
// port-level checks for the tube carriage limit clamp, bound to the top level
// depends on tcl_pkg and tube_carriage_limit_clamp
module tcl_checker
    import tcl_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // with the output register empty the whole pipe can move, so input is taken
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // every corrected position lies at or below the front plate reach bound
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[POS_W-1:0]) <= SAFE_MAX)
            && ($signed(m_axis_tdata[2*POS_W-1:POS_W]) <= SAFE_MAX)
            && ($signed(m_axis_tdata[3*POS_W-1:2*POS_W]) <= SAFE_MAX))
        else $error("corrected position out of range");

    // pad bits of the result are zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[TDATA_W-1:TUBE_COUNT*POS_W] == '0)
        else $error("result pad bits not zero");

endmodule

bind tube_carriage_limit_clamp tcl_checker u_tcl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### bench/tb_top.sv
// self-checking bench for tube_carriage_limit_clamp: stream items in, corrected positions out
// depends on tcl_pkg and the design sources; runs directed cases, then random geometry phases
module tb_top
    import tcl_pkg::*;
();

    // three positions viewed as an indexable vector, tube 1 at index 0
    typedef logic [TUBE_COUNT-1:0][POS_W-1:0] t_pos_vec;

    // register indexes the block has no register behind, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam logic [THK_W-1:0] THK_MAX = '1;
    localparam longint POS_MIN = -(64'sd1 <<< (POS_W - 1));
    localparam longint POS_MAX = (64'sd1 <<< (POS_W - 1)) - 1;

    // tip keeps this far behind the next outer tip, per tube
    localparam longint TIP_MARGIN [1:TUBE_COUNT] = '{1000, 10000, 1000};
    // tip reach ahead of the front plate per remaining tube
    localparam longint TIP_STEP = 1000;

    localparam int PIPE_DEPTH  = 4;     // pipeline registers from input to output
    localparam int STALL_LIMIT = 5000;  // cycles with work pending but no handshake
    localparam int PHASE_ITEMS = 180;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata = '0;   // want_pos_one, want_pos_two, want_pos_three, pad
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;        // safe_pos_one, safe_pos_two, safe_pos_three, pad

    // copy of the geometry registers as the block should hold them
    logic [LEN_W-1:0] len_one   = LEN_RESET;
    logic [LEN_W-1:0] len_two   = LEN_RESET;
    logic [LEN_W-1:0] len_three = LEN_RESET;
    logic [THK_W-1:0] plate_front  = FRONT_RESET;
    logic [THK_W-1:0] plate_back   = BACK_RESET;
    logic [THK_W-1:0] plate_offset = OFFSET_RESET;

    t_pos_set safe_pos_due[$];   // corrected positions still owed by the block
    int       mismatch_count = 0;
    int       stall_cycles = 0;
    int       send_idle_pct = 0;  // chance per cycle that the sender holds back
    int       rcv_stall_pct = 0;  // chance per cycle that the receiver stalls

    tube_carriage_limit_clamp u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    // corrected positions for one request, clamps applied tube by tube
    function automatic t_pos_set clamp_request(input t_pos_set want);
        longint   len [0:TUBE_COUNT];
        longint   pos [0:TUBE_COUNT];
        longint   front;
        longint   back;
        longint   offset;
        longint   prev;
        longint   prev_front;
        longint   ahead;
        longint   reach;
        longint   b;
        t_pos_set safe;
        front  = longint'(plate_front);
        back   = longint'(plate_back);
        offset = longint'(plate_offset);
        len[1] = longint'(len_one);
        len[2] = longint'(len_two);
        len[3] = longint'(len_three);
        // virtual outer tube: no plate, three tube-1 lengths long
        len[0] = 3 * len[1];
        pos[0] = -2 * len[1];
        pos[1] = longint'(want.one);
        pos[2] = longint'(want.two);
        pos[3] = longint'(want.three);
        for (int i = 1; i <= TUBE_COUNT; i++) begin
            b          = pos[i];
            prev       = pos[i-1];
            prev_front = (i == 1) ? 0 : front;
            // clear of the carriage behind
            if (b - back < prev + prev_front)
                b = prev + prev_front + back;
            // room for the carriages still ahead plus the front offset
            ahead = (TUBE_COUNT - i) * (front + back);
            if (b + front > -offset - ahead)
                b = -offset - ahead - front;
            // tip stays behind the next outer tip
            if (b + len[i] > prev + len[i-1] - TIP_MARGIN[i])
                b = prev + len[i-1] - len[i] - TIP_MARGIN[i];
            // tip stays ahead of the front plate
            reach = TIP_STEP * (TUBE_COUNT - i + 1);
            if (b + len[i] - reach < 0)
                b = reach - len[i];
            pos[i] = b;
        end
        safe.one   = t_pos'(pos[1]);
        safe.two   = t_pos'(pos[2]);
        safe.three = t_pos'(pos[3]);
        return safe;
    endfunction

    // mostly positions near the limits of a tube of this length, some anywhere
    function automatic t_pos rand_position(input logic [LEN_W-1:0] len);
        longint v;
        if ($urandom_range(99) < 25)
            return t_pos'($urandom);
        v = 30000 - longint'($urandom_range(2 * int'(len) + 150000, 0));
        if (v < POS_MIN)
            v = POS_MIN;
        return t_pos'(v);
    endfunction

    function automatic logic [LEN_W-1:0] rand_length();
        case ($urandom_range(2))
            0:       return LEN_W'($urandom);
            1:       return LEN_W'($urandom_range(20000));
            default: return LEN_W'($urandom_range(400000, 50000));
        endcase
    endfunction

    function automatic logic [THK_W-1:0] rand_thickness();
        if ($urandom_range(1))
            return THK_W'($urandom);
        return THK_W'($urandom_range(20000));
    endfunction

    // one register write; bits above the register width are dropped
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_TUBE_ONE_LEN:   len_one      = data[LEN_W-1:0];
            CFG_TUBE_TWO_LEN:   len_two      = data[LEN_W-1:0];
            CFG_TUBE_THREE_LEN: len_three    = data[LEN_W-1:0];
            CFG_PLATE_FRONT:    plate_front  = data[THK_W-1:0];
            CFG_PLATE_BACK:     plate_back   = data[THK_W-1:0];
            CFG_FRONT_OFFSET:   plate_offset = data[THK_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // all six registers; thickness writes carry junk in the upper data bits
    task automatic set_geometry(input logic [LEN_W-1:0] l1, input logic [LEN_W-1:0] l2,
                                input logic [LEN_W-1:0] l3, input logic [THK_W-1:0] front,
                                input logic [THK_W-1:0] back, input logic [THK_W-1:0] offset);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_TUBE_ONE_LEN, l1);
        write_reg(CFG_TUBE_TWO_LEN, l2);
        write_reg(CFG_TUBE_THREE_LEN, l3);
        write_reg(CFG_PLATE_FRONT, {junk[CFG_DATA_W-1:THK_W], front});
        write_reg(CFG_PLATE_BACK, {junk[CFG_DATA_W-1:THK_W], back});
        write_reg(CFG_FRONT_OFFSET, {junk[CFG_DATA_W-1:THK_W], offset});
    endtask

    // hand one item to the block, with random sender gaps before it
    task automatic push_request(input t_pos_set want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= TDATA_W'({$urandom, $urandom, $urandom});
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, want};
        do @(posedge i_clk); while (!s_axis_tready);
        // owe the corrected item, appended at the tail
        safe_pos_due = {safe_pos_due, clamp_request(want)};
    endtask

    task automatic push_positions(input longint p1, input longint p2, input longint p3);
        t_pos_set want;
        want.one   = t_pos'(p1);
        want.two   = t_pos'(p2);
        want.three = t_pos'(p3);
        push_request(want);
    endtask

    // sender stops until every owed result is back and the pipeline is empty
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (safe_pos_due.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
    endtask

    // reset geometry: zero lengths, so every tube ends up pinned near the front plate
    task automatic test_field_extremes();
        push_positions(0, 0, 0);
        push_positions(POS_MAX, POS_MAX, POS_MAX);
        push_positions(POS_MIN, POS_MIN, POS_MIN);
        push_positions(-1, -1, -1);
        // alternating bit patterns so every input bit takes both values
        push_positions(longint'(22'sh155555), longint'(22'sh2aaaaa), longint'(22'sh155555));
        push_positions(longint'(22'sh2aaaaa), longint'(22'sh155555), longint'(22'sh2aaaaa));
        wait_drained();
    endtask

    // positions on both sides of each clamp threshold under a plausible geometry
    task automatic test_clamp_cases();
        set_geometry(300000, 200000, 100000, 10000, 10000, 25000);
        push_positions(-2000000, -2000000, -2000000);   // far behind, rear clamp
        push_positions(-75000, -55000, -35000);         // exactly at room-ahead limits
        push_positions(-74999, -54999, -34999);         // just past room-ahead limits
        push_positions(-297000, -95000, -300000);       // tube 1 on front plate limit
        push_positions(-297001, -300000, -200000);      // tube 1 just behind it
        push_positions(-150000, -60000, -45000);
        push_positions(-150000, -100000, -101000);      // tube 3 behind tube 2, rear clamp
        push_positions(-200000, -40000, -160000);
        push_positions(-100000, -250000, -250000);      // inner carriages behind outer
        push_positions(-90000, -70000, -61000);
        push_positions(POS_MAX, POS_MIN, 0);
        wait_drained();
        // no plates and no offset: tube 1 tip limit is the one that bites
        set_geometry(300000, 200000, 100000, 0, 0, 0);
        push_positions(0, 0, 0);
        push_positions(-500, -800, -900);
        push_positions(-1001, -190000, -95000);
        wait_drained();
    endtask

    // writes to indexes with no register behind them must change nothing
    task automatic test_spare_index_writes();
        write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
        push_positions(-1000, -2000, -3000);
        push_positions(-150000, -60000, -45000);
        wait_drained();
    endtask

    // geometry phases with random requests and rotating idle patterns
    task automatic test_random_geometry();
        t_pos_set want;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_geometry(300000, 200000, 100000, 10000, 10000, 25000);
                1: set_geometry(LEN_MAX, LEN_MAX, LEN_MAX, THK_MAX, THK_MAX, THK_MAX);
                2: set_geometry('0, '0, '0, '0, '0, '0);
                3: set_geometry(LEN_MAX, LEN_MAX, LEN_MAX, '0, '0, '0);
                default: set_geometry(rand_length(), rand_length(), rand_length(),
                                      rand_thickness(), rand_thickness(), rand_thickness());
            endcase
            // no idling, sender gaps, receiver stalls, then both
            case (phase % 4)
                0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; rcv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rcv_stall_pct = 52; end
                default: begin send_idle_pct = 16; rcv_stall_pct = 16; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender holds off mid-phase until the block has emptied
                if (phase == 1 && n == PHASE_ITEMS / 2)
                    wait_drained();
                want.one   = rand_position(len_one);
                want.two   = rand_position(len_two);
                want.three = rand_position(len_three);
                push_request(want);
            end
            wait_drained();
            send_idle_pct = 0;
            rcv_stall_pct = 0;
        end
    endtask

    // compare each delivered item with the oldest owed result
    always @(posedge i_clk) begin : result_check
        t_pos_vec got_vec;
        t_pos_vec want_vec;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_vec = t_pos_vec'(m_axis_tdata[TUBE_COUNT*POS_W-1:0]);
            if (safe_pos_due.size() == 0) begin
                $display("%0t: unexpected result, expected none got %h", $time, got_vec);
                mismatch_count++;
            end else begin
                want_vec = t_pos_vec'(safe_pos_due.pop_front());
                for (int k = 0; k < TUBE_COUNT; k++) begin
                    if (got_vec[k] !== want_vec[k]) begin
                        $display("%0t: safe_pos %0d expected %0d got %0d", $time, k + 1,
                                 $signed(want_vec[k]), $signed(got_vec[k]));
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // watchdog: work pending but nothing moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (safe_pos_due.size() == 0 && !s_axis_tvalid)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_clamp_cases();
        test_spare_index_writes();
        test_random_geometry();
        // give any stray results time to show up
        wait_drained();
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);
        if (mismatch_count == 0 && safe_pos_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### tube_carriage_limit_clamp.f
design/tcl_pkg.sv
design/tcl_clamp.sv
design/tube_carriage_limit_clamp.sv
design/tcl_checker.sv
bench/tb_top.sv
